// ===== hdl/jhe_pkg.sv =====
// Package for the joystick hysteresis block: word types, register codes and reset values.
package jhe_pkg;

  // Sample width of the ADC words.
  localparam int SAMPLE_BITS = 12;
  // Width of the level registers and of the averaged value in a result word.
  localparam int LEVEL_W     = 12;
  localparam int AVG_W       = 12;
  localparam int PLEN_W      = 16;
  localparam int NUM_OUTS    = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [LEVEL_W-1:0]  HIGH_ENTER_RST = 12'd3800;
  localparam logic [LEVEL_W-1:0]  HIGH_EXIT_RST  = 12'd3600;
  localparam logic [LEVEL_W-1:0]  LOW_ENTER_RST  = 12'd300;
  localparam logic [LEVEL_W-1:0]  LOW_EXIT_RST   = 12'd500;
  localparam logic [PLEN_W-1:0]   PULSE_LEN_RST  = 16'd120;
  localparam logic [NUM_OUTS-1:0] PULSE_MASK_RST = 4'd13;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_ENTER = 3'd0,
    CFG_HIGH_EXIT  = 3'd1,
    CFG_LOW_ENTER  = 3'd2,
    CFG_LOW_EXIT   = 3'd3,
    CFG_PULSE_LEN  = 3'd4,
    CFG_PULSE_MASK = 3'd5
  } cfg_idx_t;

  // Request type codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Input word.
  typedef struct packed {
    logic                   req_type;
    logic                   axis_select;
    logic [SAMPLE_BITS-1:0] sample_first;
    logic [SAMPLE_BITS-1:0] sample_second;
    logic [SAMPLE_BITS-1:0] sample_third;
  } in_t;

  // Result word.
  typedef struct packed {
    logic                out_x_high;
    logic                out_x_low;
    logic                out_y_high;
    logic                out_y_low;
    logic [AVG_W-1:0]    average_value;
    logic [NUM_OUTS-1:0] zone_flags;
  } res_t;

endpackage

// ===== hdl/joystick_hysteresis_event_outputs.sv =====
// Top level: sample averaging, hysteresis detectors and pulse/toggle output state.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready   jhe_pkg::in_t
//   out_     output     out_valid / out_ready jhe_pkg::res_t
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// Each word is held in the input register, then passes through the divide-by-three multiply
// and the detector compares into the result register. A new word is accepted every cycle
// unless both registers are full and the result is not taken; the input register and the
// result register each hold one word, so a stalled result still lets one further word in.
// Synchronous active-low reset clears the detector, output and pulse state and loads the
// register defaults.
module joystick_hysteresis_event_outputs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  jhe_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output jhe_pkg::res_t                        out_data,
  input  logic                                 cfg_we,
  input  logic [jhe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jhe_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SB      = jhe_pkg::SAMPLE_BITS;
  localparam int SUM_W   = SB + 2;
  localparam int PROD_W  = 2 * SUM_W;
  localparam int DIV3_K  = SUM_W + 1;
  localparam logic [SUM_W-1:0] DIV3_M = SUM_W'((2 ** DIV3_K + 2) / 3);
  localparam int CMP_W   = (SB > jhe_pkg::LEVEL_W) ? SB : jhe_pkg::LEVEL_W;
  localparam int NO      = jhe_pkg::NUM_OUTS;
  localparam int PW      = jhe_pkg::PLEN_W;

  // Configuration registers.
  logic [jhe_pkg::LEVEL_W-1:0] high_enter_r, high_exit_r, low_enter_r, low_exit_r;
  logic [PW-1:0]               pulse_len_r;
  logic [NO-1:0]               pulse_mask_r;

  // Pipeline registers.
  logic          s1_valid_r;
  jhe_pkg::in_t  s1_data_r;
  logic          out_valid_r;
  jhe_pkg::res_t out_data_r;
  logic          s1_go;

  // Detector and output state.
  logic [NO-1:0]   zone_r, zone_nxt;
  logic [NO-1:0]   level_r, level_nxt;
  logic [PW-1:0]   rem_r [NO];
  logic [PW-1:0]   rem_nxt [NO];

  // Datapath signals.
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [SB-1:0]     avg;
  logic [CMP_W-1:0]  avg_c;
  logic              hi_enter, hi_leave, lo_enter, lo_leave;
  logic [PW-1:0]     plen_eff;
  logic              is_tick;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_enter_r <= jhe_pkg::HIGH_ENTER_RST;
      high_exit_r  <= jhe_pkg::HIGH_EXIT_RST;
      low_enter_r  <= jhe_pkg::LOW_ENTER_RST;
      low_exit_r   <= jhe_pkg::LOW_EXIT_RST;
      pulse_len_r  <= jhe_pkg::PULSE_LEN_RST;
      pulse_mask_r <= jhe_pkg::PULSE_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jhe_pkg::CFG_HIGH_ENTER: high_enter_r <= cfg_data[jhe_pkg::LEVEL_W-1:0];
        jhe_pkg::CFG_HIGH_EXIT:  high_exit_r  <= cfg_data[jhe_pkg::LEVEL_W-1:0];
        jhe_pkg::CFG_LOW_ENTER:  low_enter_r  <= cfg_data[jhe_pkg::LEVEL_W-1:0];
        jhe_pkg::CFG_LOW_EXIT:   low_exit_r   <= cfg_data[jhe_pkg::LEVEL_W-1:0];
        jhe_pkg::CFG_PULSE_LEN:  pulse_len_r  <= cfg_data[PW-1:0];
        jhe_pkg::CFG_PULSE_MASK: pulse_mask_r <= cfg_data[NO-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Average of three samples: multiply by the reciprocal of three, exact over the sum range.
  assign sum  = SUM_W'(s1_data_r.sample_first) + SUM_W'(s1_data_r.sample_second)
              + SUM_W'(s1_data_r.sample_third);
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_M);
  assign avg  = prod[DIV3_K +: SB];

  assign is_tick = (s1_data_r.req_type == jhe_pkg::REQ_TICK);
  assign avg_c   = is_tick ? '0 : CMP_W'(avg);

  // Zone compares, shared by both axes since only one axis is served per word.
  assign hi_enter = avg_c >= CMP_W'(high_enter_r);
  assign hi_leave = avg_c <  CMP_W'(high_exit_r);
  assign lo_enter = avg_c <= CMP_W'(low_enter_r);
  assign lo_leave = avg_c >  CMP_W'(low_exit_r);

  // A zero pulse length runs for one tick.
  assign plen_eff = (pulse_len_r == '0) ? PW'(1) : pulse_len_r;

  // Next state of each detector and its output.
  always_comb begin
    logic enter;
    logic leave;
    logic mine;
    for (int i = 0; i < NO; i++) begin
      zone_nxt[i]  = zone_r[i];
      level_nxt[i] = level_r[i];
      rem_nxt[i]   = rem_r[i];
      enter        = (i % 2 == 1) ? lo_enter : hi_enter;
      leave        = (i % 2 == 1) ? lo_leave : hi_leave;
      mine         = (s1_data_r.axis_select == (i >= 2));
      if (is_tick) begin
        if (rem_r[i] != '0) begin
          rem_nxt[i] = rem_r[i] - PW'(1);
          if (rem_r[i] == PW'(1)) begin
            level_nxt[i] = 1'b0;
          end
        end
      end else if (mine) begin
        if (!zone_r[i] && enter) begin
          zone_nxt[i] = 1'b1;
          if (pulse_mask_r[i]) begin
            level_nxt[i] = 1'b1;
            rem_nxt[i]   = plen_eff;
          end else begin
            level_nxt[i] = !level_r[i];
            rem_nxt[i]   = '0;
          end
        end else if (zone_r[i] && leave) begin
          zone_nxt[i] = 1'b0;
        end
      end
    end
  end

  // State registers advance with each word that reaches the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r  <= '0;
      level_r <= '0;
      for (int i = 0; i < NO; i++) begin
        rem_r[i] <= '0;
      end
    end else if (s1_go) begin
      zone_r  <= zone_nxt;
      level_r <= level_nxt;
      for (int i = 0; i < NO; i++) begin
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r.out_x_high    <= level_nxt[0];
      out_data_r.out_x_low     <= level_nxt[1];
      out_data_r.out_y_high    <= level_nxt[2];
      out_data_r.out_y_low     <= level_nxt[3];
      out_data_r.average_value <= avg_c[jhe_pkg::AVG_W-1:0];
      out_data_r.zone_flags    <= zone_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A running pulse always holds its output high.
  a_pulse_high: assert property (@(posedge clk) disable iff (!rst_n)
    ((rem_r[0] == '0) || level_r[0]) && ((rem_r[1] == '0) || level_r[1]) &&
    ((rem_r[2] == '0) || level_r[2]) && ((rem_r[3] == '0) || level_r[3]))
    else $error("pulse counter running with its output low");

  // A tick word never changes the zone flags.
  a_tick_zones: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && is_tick) |=> (out_data_r.zone_flags == $past(zone_r)))
    else $error("tick word changed the zone flags");

  // The input stalls only when both registers are full and the result is not taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");
`endif

endmodule

// ===== verif/tb_joystick_hysteresis_event_outputs.sv =====
// Self-checking testbench for the joystick hysteresis block: random and directed words.
module tb_joystick_hysteresis_event_outputs;
  import jhe_pkg::*;

  // Register indexes beyond the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  // Number of cycles the receiver holds off during the back-pressure phase.
  localparam int HOLD_CYCLES  = 60;
  // Cycles without any accepted word before the run is abandoned.
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_WORDS  = 50;
  localparam int NUM_PHASES   = 8;
  // Width of one input word.
  localparam int IN_W         = $bits(in_t);

  // Tracks the zone, output and pulse state and holds the results still owed by the block.
  class jhe_scoreboard;
    logic [LEVEL_W-1:0]  hi_enter;
    logic [LEVEL_W-1:0]  hi_exit;
    logic [LEVEL_W-1:0]  lo_enter;
    logic [LEVEL_W-1:0]  lo_exit;
    logic [PLEN_W-1:0]   pulse_len;
    logic [NUM_OUTS-1:0] pulse_mask;
    bit                  in_zone [NUM_OUTS];
    bit                  level [NUM_OUTS];
    logic [PLEN_W-1:0]   ticks_left [NUM_OUTS];
    res_t                owed [$];
    int                  mismatches;

    function new();
      hi_enter   = HIGH_ENTER_RST;
      hi_exit    = HIGH_EXIT_RST;
      lo_enter   = LOW_ENTER_RST;
      lo_exit    = LOW_EXIT_RST;
      pulse_len  = PULSE_LEN_RST;
      pulse_mask = PULSE_MASK_RST;
      for (int k = 0; k < NUM_OUTS; k++) begin
        in_zone[k]    = 1'b0;
        level[k]      = 1'b0;
        ticks_left[k] = '0;
      end
      mismatches = 0;
    endfunction

    // Mirrors a register write; unknown indexes leave everything unchanged.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_HIGH_ENTER: hi_enter   = data[LEVEL_W-1:0];
        CFG_HIGH_EXIT:  hi_exit    = data[LEVEL_W-1:0];
        CFG_LOW_ENTER:  lo_enter   = data[LEVEL_W-1:0];
        CFG_LOW_EXIT:   lo_exit    = data[LEVEL_W-1:0];
        CFG_PULSE_LEN:  pulse_len  = data[PLEN_W-1:0];
        CFG_PULSE_MASK: pulse_mask = data[NUM_OUTS-1:0];
        default: ;
      endcase
    endfunction

    // An entry either starts (or restarts) a pulse or inverts the output.
    function void fire(int k);
      if (pulse_mask[k]) begin
        level[k]      = 1'b1;
        ticks_left[k] = (pulse_len == '0) ? PLEN_W'(1) : pulse_len;
      end else begin
        level[k]      = !level[k];
        ticks_left[k] = '0;
      end
    endfunction

    // Advances the state by one accepted input word and queues the result it causes.
    function void note_word(in_t w);
      res_t want;
      int   avg;
      int   hi;
      int   lo;
      avg = 0;
      if (w.req_type == REQ_TICK) begin
        for (int k = 0; k < NUM_OUTS; k++) begin
          if (ticks_left[k] != '0) begin
            ticks_left[k] = ticks_left[k] - PLEN_W'(1);
            if (ticks_left[k] == '0) level[k] = 1'b0;
          end
        end
      end else begin
        avg = (int'(w.sample_first) + int'(w.sample_second) + int'(w.sample_third)) / 3;
        hi  = w.axis_select ? 2 : 0;
        lo  = hi + 1;
        if (!in_zone[hi] && avg >= int'(hi_enter)) begin
          in_zone[hi] = 1'b1;
          fire(hi);
        end else if (in_zone[hi] && avg < int'(hi_exit)) begin
          in_zone[hi] = 1'b0;
        end
        if (!in_zone[lo] && avg <= int'(lo_enter)) begin
          in_zone[lo] = 1'b1;
          fire(lo);
        end else if (in_zone[lo] && avg > int'(lo_exit)) begin
          in_zone[lo] = 1'b0;
        end
      end
      want.out_x_high    = level[0];
      want.out_x_low     = level[1];
      want.out_y_high    = level[2];
      want.out_y_low     = level[3];
      want.average_value = avg[AVG_W-1:0];
      want.zone_flags    = {in_zone[3], in_zone[2], in_zone[1], in_zone[0]};
      owed.push_back(want);
    endfunction

    // Compares one accepted result word with the oldest owed one.
    function void check_word(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: xh=%0d xl=%0d yh=%0d yl=%0d avg=%0d zones=%b",
                   got.out_x_high, got.out_x_low, got.out_y_high, got.out_y_low,
                   got.average_value, got.zone_flags);
        return;
      end
      want = owed.pop_front();
      if (got.out_x_high !== want.out_x_high || got.out_x_low !== want.out_x_low ||
          got.out_y_high !== want.out_y_high || got.out_y_low !== want.out_y_low ||
          got.average_value !== want.average_value || got.zone_flags !== want.zone_flags) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected xh=%0d xl=%0d yh=%0d yl=%0d avg=%0d zones=%b",
                   want.out_x_high, want.out_x_low, want.out_y_high, want.out_y_low,
                   want.average_value, want.zone_flags);
          $display("                 got      xh=%0d xl=%0d yh=%0d yl=%0d avg=%0d zones=%b",
                   got.out_x_high, got.out_x_low, got.out_y_high, got.out_y_low,
                   got.average_value, got.zone_flags);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  res_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  jhe_scoreboard sb;
  bit            send_quiet;
  bit            recv_quiet;
  bit            hold_req;
  int            idle_cycles;

  joystick_hysteresis_event_outputs u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a period of two time units.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Every accepted result word is checked against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  // Watchdog: gives up once no word has moved on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls per result word, plus one long hold-off on request.
  initial begin
    int stall;
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = recv_quiet ? 0 : $urandom_range(0, 7);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Offers one input word after a random gap and waits until it is accepted.
  task automatic push_word(in_t w);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  // Stops offering words and waits until every owed result has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the block is idle whenever this is called.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  function automatic in_t sample_word(logic axis, int a, int b, int c);
    in_t w;
    w.req_type      = REQ_SAMPLE;
    w.axis_select   = axis;
    w.sample_first  = a[SAMPLE_BITS-1:0];
    w.sample_second = b[SAMPLE_BITS-1:0];
    w.sample_third  = c[SAMPLE_BITS-1:0];
    return w;
  endfunction

  // A tick carries random junk in the fields it does not use.
  function automatic in_t tick_word();
    in_t w;
    w          = in_t'(IN_W'({$urandom, $urandom}));
    w.req_type = REQ_TICK;
    return w;
  endfunction

  function automatic int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Random word: a tick, or a sample set whose average often sits near one of the current levels.
  function automatic in_t random_word();
    int target;
    int s1;
    int s2;
    int s3;
    if ($urandom_range(0, 9) < 3) return tick_word();
    case ($urandom_range(0, 5))
      0:       target = int'(sb.hi_enter) + $urandom_range(0, 6) - 3;
      1:       target = int'(sb.hi_exit) + $urandom_range(0, 6) - 3;
      2:       target = int'(sb.lo_enter) + $urandom_range(0, 6) - 3;
      3:       target = int'(sb.lo_exit) + $urandom_range(0, 6) - 3;
      4:       target = $urandom_range(0, 4095);
      default: target = $urandom_range(0, 1) ? 4095 : 0;
    endcase
    target = clamp_sample(target);
    if ($urandom_range(0, 3) == 0) begin
      s1 = $urandom_range(0, 4095);
      s2 = $urandom_range(0, 4095);
      s3 = $urandom_range(0, 4095);
    end else begin
      s1 = clamp_sample(target + $urandom_range(0, 4) - 2);
      s2 = clamp_sample(target + $urandom_range(0, 4) - 2);
      s3 = clamp_sample(3 * target - s1 - s2 + $urandom_range(0, 2));
    end
    return sample_word(1'($urandom_range(0, 1)), s1, s2, s3);
  endfunction

  // Writes a whole register setting of the given kind; junk rides in the unused data bits.
  task automatic pick_setting(int kind);
    logic [LEVEL_W-1:0]  he;
    logic [LEVEL_W-1:0]  hx;
    logic [LEVEL_W-1:0]  le;
    logic [LEVEL_W-1:0]  lx;
    logic [PLEN_W-1:0]   pl;
    logic [NUM_OUTS-1:0] pm;
    logic [3:0]          junk;
    logic [11:0]         junk_wide;
    case (kind)
      0: begin
        he = HIGH_ENTER_RST;
        hx = HIGH_EXIT_RST;
        le = LOW_ENTER_RST;
        lx = LOW_EXIT_RST;
        pl = PLEN_W'($urandom_range(1, 6));
        pm = NUM_OUTS'($urandom_range(0, 15));
      end
      1: begin
        // Every zone entered at once and never left.
        he = '0;
        hx = '0;
        le = '1;
        lx = '1;
        pl = '1;
        pm = '1;
      end
      2: begin
        // Enter levels on the wrong side of the exit levels.
        he = LEVEL_W'($urandom_range(0, 2000));
        hx = LEVEL_W'($urandom_range(2000, 4095));
        le = LEVEL_W'($urandom_range(2000, 4095));
        lx = LEVEL_W'($urandom_range(0, 2000));
        pl = PLEN_W'($urandom_range(0, 6));
        pm = NUM_OUTS'($urandom_range(0, 15));
      end
      4: begin
        // Zones only at the very ends of the range, all outputs toggling.
        he = '1;
        hx = '1;
        le = '0;
        lx = '0;
        pl = 16'd1;
        pm = '0;
      end
      default: begin
        le = LEVEL_W'($urandom_range(0, 1000));
        lx = le + LEVEL_W'($urandom_range(0, 200));
        hx = LEVEL_W'($urandom_range(2500, 3800));
        he = hx + LEVEL_W'($urandom_range(0, 200));
        pl = PLEN_W'($urandom_range(0, 6));
        pm = NUM_OUTS'($urandom_range(0, 15));
      end
    endcase
    junk = 4'($urandom);
    set_reg(CFG_HIGH_ENTER, {junk, he});
    junk = 4'($urandom);
    set_reg(CFG_HIGH_EXIT, {junk, hx});
    junk = 4'($urandom);
    set_reg(CFG_LOW_ENTER, {junk, le});
    junk = 4'($urandom);
    set_reg(CFG_LOW_EXIT, {junk, lx});
    set_reg(CFG_PULSE_LEN, pl);
    junk_wide = 12'($urandom);
    set_reg(CFG_PULSE_MASK, {junk_wide, pm});
  endtask

  // Main sequence: reset, directed words, then random phases under changing settings.
  initial begin
    int kinds [NUM_PHASES];
    kinds      = '{0, 3, 1, 3, 2, 3, 4, 3};
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    hold_req   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Short pulses under the reset mask; spare indexes must not disturb anything.
    set_reg(CFG_PULSE_LEN, 16'd2);
    set_reg(CFG_SPARE_LO, 16'hFFFF);
    set_reg(CFG_SPARE_HI, 16'h0001);
    push_word(tick_word());
    push_word(sample_word(1'b0, 0, 0, 0));
    push_word(sample_word(1'b0, 4095, 4095, 4095));
    push_word(sample_word(1'b0, 4095, 4095, 4094));
    push_word(sample_word(1'b0, 3599, 3599, 3599));
    // Re-entry while the pulse still runs reloads its count.
    push_word(sample_word(1'b0, 3800, 3800, 3800));
    push_word(tick_word());
    push_word(tick_word());
    push_word(sample_word(1'b1, 300, 300, 300));
    push_word(sample_word(1'b1, 500, 500, 500));
    push_word(sample_word(1'b1, 501, 501, 501));
    push_word(sample_word(1'b1, 300, 300, 302));
    push_word(sample_word(1'b1, 3800, 3800, 3800));
    push_word(sample_word(1'b0, 0, 0, 2));
    push_word(tick_word());
    push_word(tick_word());
    push_word(tick_word());
    drain();

    // A zero pulse length behaves as one tick.
    set_reg(CFG_PULSE_LEN, 16'd0);
    set_reg(CFG_PULSE_MASK, 16'h000F);
    push_word(sample_word(1'b1, 0, 0, 0));
    push_word(tick_word());
    push_word(sample_word(1'b1, 4095, 4095, 4095));
    push_word(tick_word());
    drain();

    // A toggle entry clears a pulse that is still counting.
    set_reg(CFG_PULSE_LEN, 16'd5);
    push_word(sample_word(1'b0, 4095, 4095, 4095));
    push_word(sample_word(1'b0, 0, 0, 0));
    drain();
    set_reg(CFG_PULSE_MASK, 16'h0000);
    push_word(sample_word(1'b0, 4095, 4095, 4095));
    push_word(tick_word());
    drain();

    // Random phases; one with a long receiver hold-off, one with no idling at all.
    for (int p = 0; p < NUM_PHASES; p++) begin
      pick_setting(kinds[p]);
      send_quiet = (p == 2) || (p == 5);
      recv_quiet = (p == 5);
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) push_word(random_word());
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
